// File: sv/qspn_pkg.sv
// -----------------------------------------------------------------------------
// qspn_pkg
// Shared types and constants of the quickselect partition node.
// -----------------------------------------------------------------------------
package qspn_pkg;

   localparam int VALUE_W = 32;
   localparam int DRAW_W  = 16;
   localparam int OP_W    = 3;
   localparam int KIND_W  = 2;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD      = 3'd0,
      OP_REQUEST   = 3'd1,
      OP_PIVOT     = 3'd2,
      OP_KEEP_HIGH = 3'd3,
      OP_KEEP_LOW  = 3'd4,
      OP_CLEAR     = 3'd5
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_COUNT  = 2'd1,
      KIND_EMPTY  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FETCH,
      ST_SCAN,
      ST_REPLY
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic mod_start;
      logic fetch;
      logic scan_run;
      logic scan_commit;
      logic rsp_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic count_zero;
      logic mod_done;
      logic scan_done;
      logic rsp_free;
      logic op_is_pivot;
   } ctrl_sts_type;

endpackage

// File: sv/quickselect_partition_node_unit.sv
// Load, clear and unused commands stay in idle; the next beat is taken straight after.
// Request runs the remainder unit (one draw bit per cycle), then one memory read, then
// the reply register; an empty list goes straight to the reply register.
// Pivot and keep walk the list through the single-read, single-write store; pivot then
// loads its reply.
// A finished reply waits in its own register while the next beat is accepted.
// Synchronous reset empties the list and zeroes the pivot; store contents stay undefined.
// -----------------------------------------------------------------------------
// quickselect_partition_node_unit
// One node of a distributed median search: list storage, sampling and partitioning.
// -----------------------------------------------------------------------------
module quickselect_partition_node_unit
   import qspn_pkg::*;
#(
   parameter int CAPACITY = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [OP_W-1:0]           req_op,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [DRAW_W-1:0]         req_random_draw,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [KIND_W-1:0]         rsp_reply_kind,
   output logic signed [VALUE_W-1:0] rsp_reply_value
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   qspn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .sts       (sts),
      .cmd       (cmd)
   );

   qspn_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_op          (req_op),
      .req_value       (req_value),
      .req_random_draw (req_random_draw),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_reply_kind  (rsp_reply_kind),
      .rsp_reply_value (rsp_reply_value)
   );

   // A command that walks the list or samples it holds off the next beat.
   a_busy_after_long_op: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_op == OP_REQUEST || req_op == OP_PIVOT ||
       req_op == OP_KEEP_HIGH || req_op == OP_KEEP_LOW)) |=> req_stall)
      else $error("beat accepted while a long command was starting");

   // The reply register is only loaded when its previous reply has gone.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("reply register overwritten");

   // The count is committed only once the walk has drained.
   a_commit_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_commit |-> sts.scan_done && cmd.scan_run)
      else $error("walk committed before it finished");

endmodule

// File: sv/qspn_mod.sv
// -----------------------------------------------------------------------------
// qspn_mod
// Restoring remainder unit: draw modulo divisor, one draw bit per cycle.
// -----------------------------------------------------------------------------
module qspn_mod
   import qspn_pkg::*;
#(
   parameter int CAPACITY = 8,
   localparam int CW = $clog2(CAPACITY + 1),
   localparam int SW = $clog2(DRAW_W)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DRAW_W-1:0] draw,
   input  logic [CW-1:0]     divisor,
   output logic              done,
   output logic [CW-1:0]     remainder
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SW-1:0]     step_ff, step_in;
   logic [DRAW_W-1:0] draw_ff, draw_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic [CW:0]       shifted;

   // The partial remainder stays below the divisor, so one subtract per bit suffices.
   always_comb begin
      shifted  = {rem_ff, draw_ff[DRAW_W-1]};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      draw_in  = draw_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         draw_in = draw;
         rem_in  = '0;
      end else if (busy_ff) begin
         draw_in = {draw_ff[DRAW_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (shifted >= {1'b0, divisor}) begin
            rem_in = CW'(shifted - {1'b0, divisor});
         end else begin
            rem_in = shifted[CW-1:0];
         end
         if (step_ff == SW'(DRAW_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      draw_ff <= draw_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: sv/qspn_datapath.sv
// -----------------------------------------------------------------------------
// qspn_datapath
// Element store, count, pivot, list walker and result register.
// -----------------------------------------------------------------------------
module qspn_datapath
   import qspn_pkg::*;
#(
   parameter int CAPACITY = 8,
   localparam int CW = $clog2(CAPACITY + 1),
   localparam int IW = $clog2(CAPACITY)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_cmd_type              cmd,
   output ctrl_sts_type              sts,
   input  logic [OP_W-1:0]           req_op,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [DRAW_W-1:0]         req_random_draw,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [KIND_W-1:0]         rsp_reply_kind,
   output logic signed [VALUE_W-1:0] rsp_reply_value
);

   logic signed [VALUE_W-1:0] mem [CAPACITY];

   op_type                    op_ff, op_in;
   logic [CW-1:0]             count_ff, count_in;
   logic signed [VALUE_W-1:0] pivot_ff, pivot_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             kept_ff, kept_in;
   logic [CW-1:0]             above_ff, above_in;
   logic                      pend_ff, pend_in;
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]         kind_ff, kind_in;
   logic signed [VALUE_W-1:0] reply_ff, reply_in;

   logic                      wr_en, rd_en, issue, keep_elem;
   logic [IW-1:0]             wr_addr, rd_addr;
   logic signed [VALUE_W-1:0] wr_data;
   logic                      mod_done;
   logic [CW-1:0]             remainder;
   logic                      rsp_free;

   qspn_mod #(.CAPACITY(CAPACITY)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .draw      (req_random_draw),
      .divisor   (count_ff),
      .done      (mod_done),
      .remainder (remainder)
   );

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign issue    = cmd.scan_run && (idx_ff < count_ff);

   always_comb begin
      if (op_ff == OP_KEEP_HIGH) begin
         keep_elem = !(pivot_ff > rd_data_ff);
      end else begin
         keep_elem = !(rd_data_ff > pivot_ff);
      end
   end

   always_comb begin
      op_in    = op_ff;
      count_in = count_ff;
      pivot_in = pivot_ff;
      idx_in   = idx_ff;
      kept_in  = kept_ff;
      above_in = above_ff;
      pend_in  = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = count_ff[IW-1:0];
      wr_data  = req_value;
      rd_en    = 1'b0;
      rd_addr  = idx_ff[IW-1:0];

      if (cmd.accept) begin
         op_in    = op_type'(req_op);
         idx_in   = '0;
         kept_in  = '0;
         above_in = '0;
         unique case (req_op)
            OP_LOAD: begin
               if (count_ff < CW'(CAPACITY)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            OP_PIVOT: begin
               pivot_in = req_value;
            end
            default: begin
            end
         endcase
      end

      if (cmd.fetch) begin
         rd_en   = 1'b1;
         rd_addr = remainder[IW-1:0];
      end

      // Reads run one element ahead of the compare; the write slot never passes the read.
      if (issue) begin
         rd_en   = 1'b1;
         idx_in  = idx_ff + 1'b1;
         pend_in = 1'b1;
      end

      if (pend_ff) begin
         if (op_ff == OP_PIVOT) begin
            if (rd_data_ff > pivot_ff) begin
               above_in = above_ff + 1'b1;
            end
         end else if (keep_elem) begin
            wr_en   = 1'b1;
            wr_addr = kept_ff[IW-1:0];
            wr_data = rd_data_ff;
            kept_in = kept_ff + 1'b1;
         end
      end

      if (cmd.scan_commit && (op_ff == OP_KEEP_HIGH || op_ff == OP_KEEP_LOW)) begin
         count_in = kept_ff;
      end
   end

   always_comb begin
      kind_in      = kind_ff;
      reply_in     = reply_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         priority if (op_ff == OP_PIVOT) begin
            kind_in  = KIND_COUNT;
            reply_in = {{(VALUE_W - CW){1'b0}}, above_ff};
         end else if (count_ff == '0) begin
            kind_in  = KIND_EMPTY;
            reply_in = '1;
         end else begin
            kind_in  = KIND_SAMPLE;
            reply_in = rd_data_ff;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pivot_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         op_ff        <= OP_LOAD;
      end else begin
         count_ff     <= count_in;
         pivot_ff     <= pivot_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
      end
      idx_ff   <= idx_in;
      kept_ff  <= kept_in;
      above_ff <= above_in;
      kind_ff  <= kind_in;
      reply_ff <= reply_in;
   end

   assign sts.count_zero  = (count_ff == '0);
   assign sts.mod_done    = mod_done;
   assign sts.scan_done   = (idx_ff >= count_ff) && !pend_ff;
   assign sts.rsp_free    = rsp_free;
   assign sts.op_is_pivot = (op_ff == OP_PIVOT);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reply_kind  = kind_ff;
   assign rsp_reply_value = reply_ff;

endmodule

// File: sv/qspn_ctrl.sv
// -----------------------------------------------------------------------------
// qspn_ctrl
// Command sequencer: accepts a beat, steps the datapath, issues the reply.
// -----------------------------------------------------------------------------
module qspn_ctrl
   import qspn_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [OP_W-1:0] req_op,
   input  ctrl_sts_type    sts,
   output ctrl_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (req_op)
                  OP_REQUEST: begin
                     if (sts.count_zero) begin
                        state_in = ST_REPLY;
                     end else begin
                        cmd.mod_start = 1'b1;
                        state_in      = ST_DIVIDE;
                     end
                  end
                  OP_PIVOT, OP_KEEP_HIGH, OP_KEEP_LOW: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            if (sts.mod_done) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_REPLY;
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               cmd.scan_commit = 1'b1;
               state_in        = sts.op_is_pivot ? ST_REPLY : ST_IDLE;
            end
         end
         ST_REPLY: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
